@@ src/assert_macros.svh @@
// Assertion macros for the RTL, included by prl_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PRL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define PRL_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ src/prl_pkg.sv @@
// Types and constants for the PCM converter with frame RMS level meter.
`timescale 1ns / 1ps

package prl_pkg;

  localparam int PRL_FRAME_DEPTH = 2048;

  localparam int RAW_W      = 32;
  localparam int PCM_W      = 16;
  localparam int LVL_W      = 16;
  localparam int SHIFT_W    = 5;
  localparam int GAIN_W     = 8;
  localparam int SQ_W       = 2 * PCM_W - 1;
  localparam int ROOT_W     = 32;
  localparam int ROOT_STEPS = 16;
  localparam int PROD_W     = LVL_W + GAIN_W + 1;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [SHIFT_W-1:0] SHIFT_RST = SHIFT_W'(14);
  localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(6);
  localparam logic [LVL_W-1:0]   LVL_MAX   = {LVL_W{1'b1}};

  typedef enum logic {
    REG_SAMPLE_SHIFT = 1'b0,
    REG_LEVEL_GAIN   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw_word;
    logic                    frame_end;
  } in_item_t;

  typedef struct packed {
    logic signed [PCM_W-1:0] pcm_sample;
    logic [LVL_W-1:0]        level;
    logic                    level_valid;
  } out_item_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] sample_shift;
    logic [GAIN_W-1:0]  level_gain;
  } cfg_t;

endpackage

@@ src/prl_apb_regs.sv @@
// APB configuration registers: sample shift and level gain.
`timescale 1ns / 1ps

module prl_apb_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [prl_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [prl_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [prl_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output prl_pkg::cfg_t                   cfg
);
  import prl_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[2]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      case (idx)
        REG_SAMPLE_SHIFT: cfg_nxt.sample_shift = pwdata[SHIFT_W-1:0];
        REG_LEVEL_GAIN:   cfg_nxt.level_gain   = pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SAMPLE_SHIFT: prdata = CFG_DATA_W'(cfg_r.sample_shift);
      REG_LEVEL_GAIN:   prdata = CFG_DATA_W'(cfg_r.level_gain);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_shift <= SHIFT_RST;
      cfg_r.level_gain   <= GAIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ src/prl_sub_unit.sv @@
// Shared compare-and-subtract unit for the divide and square root steps.
`timescale 1ns / 1ps

module prl_sub_unit #(
  parameter int W = 32
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         ge,
  output logic [W-1:0] diff
);

  logic [W:0] d;

  assign d    = {1'b0, a} - {1'b0, b};
  assign ge   = ~d[W];
  assign diff = d[W-1:0];

endmodule

@@ src/prl_core.sv @@
// Sequencer and datapath: conversion, accumulation, divide, root, scale.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module prl_core #(
  parameter int FRAME_DEPTH = prl_pkg::PRL_FRAME_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  prl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output prl_pkg::out_item_t out_data,
  input  prl_pkg::cfg_t      cfg
);
  import prl_pkg::*;

  localparam int CNT_W  = $clog2(FRAME_DEPTH + 1);
  localparam int SUM_W  = SQ_W + CNT_W;
  localparam int UW     = (CNT_W + 1 > ROOT_W) ? CNT_W + 1 : ROOT_W;
  localparam int STEP_W = $clog2(SUM_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQR,
    S_ACC,
    S_DIV,
    S_ROOT,
    S_SCALE,
    S_OUT
  } state_t;

  state_t                  state_r,     state_nxt;
  logic                    last_r,      last_nxt;
  logic signed [PCM_W-1:0] pcm_r,       pcm_nxt;
  logic [SQ_W-1:0]         sq_r,        sq_nxt;
  logic [SUM_W-1:0]        sum_r,       sum_nxt;
  logic [CNT_W-1:0]        cnt_r,       cnt_nxt;
  logic [CNT_W-1:0]        rem_r,       rem_nxt;
  logic [SUM_W-1:0]        dvd_r,       dvd_nxt;
  logic [ROOT_W-1:0]       rad_r,       rad_nxt;
  logic [ROOT_W-1:0]       res_r,       res_nxt;
  logic [ROOT_W-1:0]       bit_r,       bit_nxt;
  logic [STEP_W-1:0]       step_r,      step_nxt;
  logic [PROD_W-1:0]       prod_r,      prod_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_r,       out_nxt;

  logic                    accept;
  logic signed [RAW_W-1:0] shifted;
  logic signed [RAW_W-1:0] sq_full;
  logic [CNT_W:0]          rem_shift;
  logic [SUM_W-1:0]        quot;
  logic [UW-1:0]           u_a;
  logic [UW-1:0]           u_b;
  logic                    u_ge;
  logic [UW-1:0]           u_diff;
  logic                    load_out;

  prl_sub_unit #(.W(UW)) u_sub (
    .a    (u_a),
    .b    (u_b),
    .ge   (u_ge),
    .diff (u_diff)
  );

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign shifted   = in_data.raw_word >>> cfg.sample_shift;
  assign sq_full   = RAW_W'(pcm_r) * RAW_W'(pcm_r);
  assign rem_shift = {rem_r, dvd_r[SUM_W-1]};
  assign quot      = {dvd_r[SUM_W-2:0], u_ge};
  assign load_out  = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    if (state_r == S_DIV) begin
      u_a = UW'(rem_shift);
      u_b = UW'(cnt_r);
    end else begin
      u_a = UW'(rad_r);
      u_b = UW'(res_r + bit_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    pcm_nxt       = pcm_r;
    sq_nxt        = sq_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    rad_nxt       = rad_r;
    res_nxt       = res_r;
    bit_nxt       = bit_r;
    step_nxt      = step_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          pcm_nxt   = shifted[PCM_W-1:0];
          last_nxt  = in_data.frame_end;
          state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        sq_nxt    = sq_full[SQ_W-1:0];
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (cnt_r < CNT_W'(FRAME_DEPTH)) begin
          sum_nxt = sum_r + SUM_W'(sq_r);
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (last_r) begin
          dvd_nxt   = sum_nxt;
          rem_nxt   = '0;
          step_nxt  = STEP_W'(SUM_W - 1);
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIV: begin
        if (u_ge) begin
          rem_nxt = u_diff[CNT_W-1:0];
        end else begin
          rem_nxt = rem_shift[CNT_W-1:0];
        end
        dvd_nxt  = quot;
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          rad_nxt   = ROOT_W'(quot[SQ_W-1:0]);
          res_nxt   = '0;
          bit_nxt   = ROOT_W'(1) << (2 * (ROOT_STEPS - 1));
          step_nxt  = STEP_W'(ROOT_STEPS - 1);
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        if (u_ge) begin
          rad_nxt = u_diff[ROOT_W-1:0];
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt  = bit_r >> 2;
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        prod_nxt  = (PROD_W'(res_r[LVL_W-1:0]) * PROD_W'(cfg.level_gain)) << 1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (load_out) begin
          out_valid_nxt      = 1'b1;
          out_nxt.pcm_sample = pcm_r;
          out_nxt.level_valid = last_r;
          if (!last_r) begin
            out_nxt.level = '0;
          end else if (prod_r > PROD_W'(LVL_MAX)) begin
            out_nxt.level = LVL_MAX;
          end else begin
            out_nxt.level = prod_r[LVL_W-1:0];
          end
          if (last_r) begin
            sum_nxt = '0;
            cnt_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    last_r <= last_nxt;
    pcm_r  <= pcm_nxt;
    sq_r   <= sq_nxt;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    rad_r  <= rad_nxt;
    res_r  <= res_nxt;
    bit_r  <= bit_nxt;
    step_r <= step_nxt;
    prod_r <= prod_nxt;
    out_r  <= out_nxt;
  end

  `PRL_ASSERT(a_busy_after_accept, accept |=> (state_r == S_SQR), "accept did not start work")
  `PRL_NEVER(a_cnt_in_range, cnt_r > CNT_W'(FRAME_DEPTH), "sample count beyond frame depth")
  `PRL_NEVER(a_div_nonzero, (state_r == S_DIV) && (cnt_r == '0), "divide by zero count")
  `PRL_ASSERT(a_out_hold, (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)),
              "stalled result changed")

endmodule

@@ src/pcm_convert_rms_level.sv @@
// Top level: PCM conversion with per-frame RMS level meter.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   raw_word, frame_end
//   out_     output     out_valid/out_stall pcm_sample, level, level_valid
//   apb      input      psel/penable/pready sample_shift @0x0, level_gain @0x4
//
// An ordinary sample passes shift, square, accumulate and the result register before
// the next accept. A frame-end sample adds a restoring divide of
// 31 + clog2(FRAME_DEPTH+1) steps and 16 root steps on the shared subtractor, plus
// a scaling step. Reset is synchronous and clears the sums; out_stall holds the
// result register and the sequencer waits there.
`timescale 1ns / 1ps

module pcm_convert_rms_level #(
  parameter int FRAME_DEPTH = prl_pkg::PRL_FRAME_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  prl_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output prl_pkg::out_item_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [prl_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [prl_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [prl_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import prl_pkg::*;

  cfg_t cfg;

  prl_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  prl_core #(.FRAME_DEPTH(FRAME_DEPTH)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg       (cfg)
  );

endmodule

@@ tb/sv/pcm_convert_rms_level_test.sv @@
// Self-checking testbench for the PCM converter with frame RMS level meter.
`timescale 1ns / 1ps

module pcm_convert_rms_level_test;
  import prl_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int CALM_FIRST  = 6000;
  localparam int CALM_LAST   = 12000;
  localparam int IDLE_PCT    = 33;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  in_item_t  pending_samples[$];
  out_item_t expected_results[$];
  int        cycle_count = 0;
  int        fail_count = 0;
  logic      calm;

  logic [SHIFT_W-1:0] shift_amt = SHIFT_RST;
  logic [GAIN_W-1:0]  gain = GAIN_RST;
  logic [41:0]        energy_sum = '0;
  logic [12:0]        frame_count = '0;

  pcm_convert_rms_level dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  assign calm = (cycle_count >= CALM_FIRST) && (cycle_count < CALM_LAST);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("pcm_convert_rms_level_test failed");
      $finish;
    end
  end

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic out_item_t convert_and_meter(in_item_t item);
    logic signed [RAW_W-1:0] shifted;
    longint                  pcm;
    longint unsigned         scaled;
    out_item_t               res;
    shifted = item.raw_word >>> shift_amt;
    pcm = longint'($signed(shifted[PCM_W-1:0]));
    res.pcm_sample = shifted[PCM_W-1:0];
    res.level = '0;
    res.level_valid = item.frame_end;
    if (frame_count < PRL_FRAME_DEPTH) begin
      energy_sum = energy_sum + 42'(pcm * pcm);
      frame_count = frame_count + 1'b1;
    end
    if (item.frame_end) begin
      if (frame_count != 0) begin
        scaled = floor_root(64'(energy_sum) / 64'(frame_count)) * 2 * 64'(gain);
        res.level = (scaled > 65535) ? LVL_MAX : scaled[LVL_W-1:0];
      end
      energy_sum = '0;
      frame_count = '0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    logic     next_valid;
    in_item_t next_data;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      next_data = in_data;
      if (in_valid && !in_stall) begin
        expected_results.push_back(convert_and_meter(in_data));
        next_valid = 1'b0;
      end
      if (!next_valid && pending_samples.size() != 0 &&
          (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        next_valid = 1'b1;
        next_data = pending_samples.pop_front();
      end
      in_valid <= next_valid;
      in_data <= next_data;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected transaction: pcm_sample %0d level %0d level_valid %0b",
               $signed(out_data.pcm_sample), out_data.level, out_data.level_valid);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.pcm_sample !== want.pcm_sample) begin
          $error("pcm_sample mismatch: expected %0d, actual %0d",
                 $signed(want.pcm_sample), $signed(out_data.pcm_sample));
          fail_count++;
        end
        if (out_data.level !== want.level) begin
          $error("level mismatch: expected %0d, actual %0d", want.level, out_data.level);
          fail_count++;
        end
        if (out_data.level_valid !== want.level_valid) begin
          $error("level_valid mismatch: expected %0b, actual %0b",
                 want.level_valid, out_data.level_valid);
          fail_count++;
        end
      end
    end
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  task automatic push_sample(logic [RAW_W-1:0] raw, logic last);
    in_item_t item;
    item.raw_word = raw;
    item.frame_end = last;
    pending_samples.push_back(item);
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SAMPLE_SHIFT: shift_amt = value[SHIFT_W-1:0];
      REG_LEVEL_GAIN:   gain = value[GAIN_W-1:0];
      default:          ;
    endcase
  endtask

  task automatic set_config(int shift_val, int gain_val);
    wait_idle();
    write_register(REG_SAMPLE_SHIFT, CFG_DATA_W'(shift_val));
    write_register(REG_LEVEL_GAIN, CFG_DATA_W'(gain_val));
  endtask

  function automatic logic [RAW_W-1:0] pick_raw();
    logic [RAW_W-1:0] word;
    logic [RAW_W-1:0] amp;
    word = $urandom();
    amp = RAW_W'($urandom_range(0, 65535)) - 32'd32768;
    case ($urandom_range(0, 5))
      0: return word;
      1: return {word[31:8], 8'h00};
      2: return (amp << shift_amt) | (word & ((32'd1 << shift_amt) - 1));
      3: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      4: return RAW_W'($urandom_range(0, 15)) << shift_amt;
      default: return (word[0] ? 32'h7FF0_0000 : 32'h8010_0000) >>> (16 - shift_amt % 17);
    endcase
  endfunction

  task automatic push_frames(int count);
    int len;
    while (count > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) push_sample(pick_raw(), i == len - 1);
      count -= len;
    end
  endtask

  task automatic push_long_frame(int len);
    for (int i = 0; i < len; i++) push_sample(pick_raw(), i == len - 1);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    push_sample(32'h0000_0000, 1'b0);
    push_sample(32'h1FFF_C000, 1'b0);
    push_sample(32'hE000_0000, 1'b0);
    push_sample(32'h7FFF_FFFF, 1'b1);
    push_sample(32'h0000_4000, 1'b1);
    push_sample(32'h0000_0000, 1'b1);
    push_sample(32'hFFFF_FFFF, 1'b0);
    push_sample(32'h0000_8000, 1'b1);
    push_sample(32'h8000_0000, 1'b1);

    set_config(0, 255);
    push_sample(32'h7FFF_FFFF, 1'b0);
    push_sample(32'h0000_8000, 1'b0);
    push_sample(32'h0000_7FFF, 1'b0);
    push_sample(32'h8000_0000, 1'b1);
    push_sample(32'h0000_0001, 1'b1);
    push_sample(32'h0000_0003, 1'b1);

    set_config(31, 0);
    push_sample(32'h8000_0000, 1'b0);
    push_sample(32'h7FFF_FFFF, 1'b1);
    push_sample(32'hFFFF_FFFF, 1'b1);

    set_config(16, 1);
    push_long_frame(200);
    push_frames(40);

    set_config(14, 6);
    push_frames(40);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       set_config(0, 255);
        1:       set_config(31, 255);
        2:       set_config(16, 0);
        default: set_config($urandom_range(0, 31), $urandom_range(0, 255));
      endcase
      push_frames(250);
    end

    wait_idle();
    repeat (80) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("pcm_convert_rms_level_test passed");
    end else begin
      $display("pcm_convert_rms_level_test failed");
    end
    $finish;
  end

endmodule

@@ pcm_convert_rms_level.f @@
+incdir+src
src/prl_pkg.sv
src/prl_apb_regs.sv
src/prl_sub_unit.sv
src/prl_core.sv
src/pcm_convert_rms_level.sv
tb/sv/pcm_convert_rms_level_test.sv
